@@ rtl/core/u8u16_pkg.sv @@
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

	localparam int BYTE_W  = 8;
	localparam int UNIT_W  = 16;
	localparam int COUNT_W = 7;
	localparam int PEND_W  = 2;

	// Continuation bytes still expected in the current sequence.
	localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

	localparam logic [BYTE_W-1:0] NUL_BYTE      = 8'h00;
	localparam logic [BYTE_W-1:0] MASK_TOP1     = 8'h80;
	localparam logic [BYTE_W-1:0] MASK_TOP2     = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_TOP3     = 8'hE0;
	localparam logic [BYTE_W-1:0] MASK_TOP4     = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT_PREFIX   = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_PREFIX  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_PREFIX  = 8'hE0;
	localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'h0F;
	localparam logic [UNIT_W-1:0] TERM_UNIT     = 16'h0000;

	localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd255;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [UNIT_W-1:0]  unit_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [PEND_W-1:0]  pend_t;

endpackage

@@ rtl/core/u8u16_byte_if.sv @@
// Valid/ready channel that carries one UTF-8 byte per request.
`timescale 1ns / 1ps

interface u8u16_byte_if;
	logic                     valid;
	logic                     ready;
	logic [u8u16_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/core/u8u16_unit_if.sv @@
// Valid/ready channel that carries one UTF-16 code unit per request.
`timescale 1ns / 1ps

interface u8u16_unit_if;
	logic                          valid;
	logic                          ready;
	logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
	logic                          is_last;
	logic [u8u16_pkg::COUNT_W-1:0] unit_total;

	modport source (output valid, output code_unit, output is_last, output unit_total,
		input ready);
	modport sink   (input valid, input code_unit, input is_last, input unit_total,
		output ready);
endinterface

@@ rtl/core/utf8_to_utf16_decoder_core.sv @@
// UTF-8 to UTF-16 (basic multilingual plane) stream transcoder, top level.
`timescale 1ns / 1ps

// Takes a NUL-terminated UTF-8 string one byte per request and returns one
// 16-bit code unit per completed one-, two- or three-byte sequence, plus a
// zero terminator unit (is_last high, unit_total = units including the
// terminator) for every NUL byte. The decode step is a single level of
// logic between the per-string state registers and the output register, so
// a byte is accepted in every cycle in which the output register is empty or
// is being drained. Results are registered and appear in the cycle after the
// byte that completes them. Four-byte leads, stray continuation bytes and bad
// continuations stop the string; later bytes up to the NUL are dropped, as
// are bytes once capacity_bytes/2-1 units (clamped at zero) are written.
// Overlong forms pass through unchanged. The capacity register resets to
// 255 and is read live: a write applies from the next byte.
module utf8_to_utf16_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [u8u16_pkg::BYTE_W-1:0]  cfg_wr_data,
	u8u16_byte_if.sink                    byte_in,
	u8u16_unit_if.source                  unit_out
);
	import u8u16_pkg::*;

	// Configuration and per-string state.
	byte_t  capacity_q;
	pend_t  pending_q;
	unit_t  partial_q;
	count_t written_q;
	logic   stopped_q;

	// Output register.
	logic   out_valid_q;
	unit_t  out_unit_q;
	logic   out_last_q;
	count_t out_total_q;

	// Step logic.
	byte_t  b;
	logic   accept;
	count_t cap_half;
	count_t usable;
	pend_t  pending_d;
	unit_t  partial_d;
	count_t written_d;
	logic   stopped_d;
	logic   emit;
	unit_t  emit_unit;
	logic   emit_last;
	count_t emit_total;
	count_t written_inc;

	// Advance whenever the output register is free or drains this cycle.
	assign byte_in.ready = !out_valid_q || unit_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.in_byte;

	// Usable units: half the byte capacity minus one, clamped at zero.
	assign cap_half    = capacity_q[BYTE_W-1:1];
	assign usable      = (cap_half == '0) ? '0 : count_t'(cap_half - count_t'(1));
	assign written_inc = count_t'(written_q + count_t'(1));

	always_comb begin
		pending_d  = pending_q;
		partial_d  = partial_q;
		written_d  = written_q;
		stopped_d  = stopped_q;
		emit       = 1'b0;
		emit_unit  = TERM_UNIT;
		emit_last  = 1'b0;
		emit_total = '0;
		if (b == NUL_BYTE) begin
			// Terminator: report the total and clear the string state.
			emit       = 1'b1;
			emit_last  = 1'b1;
			emit_total = written_inc;
			pending_d  = PEND_NONE;
			partial_d  = '0;
			written_d  = '0;
			stopped_d  = 1'b0;
		end else if (stopped_q) begin
			// Drop everything up to the NUL.
		end else if (pending_q != PEND_NONE) begin
			if ((b & MASK_TOP2) != CONT_PREFIX) begin
				// Bad continuation: drop the partial unit and stop.
				pending_d = PEND_NONE;
				partial_d = '0;
				stopped_d = 1'b1;
			end else if (pending_q == PEND_TWO) begin
				partial_d = partial_q | {4'h0, b[5:0], 6'h00};
				pending_d = PEND_ONE;
			end else begin
				pending_d = PEND_NONE;
				partial_d = '0;
				emit      = 1'b1;
				emit_unit = partial_q | {10'h000, b[5:0]};
				written_d = written_inc;
			end
		end else if (written_q >= usable) begin
			// Capacity full: hold off new sequences until the NUL.
			stopped_d = 1'b1;
		end else if ((b & MASK_TOP1) == NUL_BYTE) begin
			emit      = 1'b1;
			emit_unit = {8'h00, b};
			written_d = written_inc;
		end else if ((b & MASK_TOP3) == LEAD2_PREFIX) begin
			partial_d = {5'h00, b[4:0], 6'h00};
			pending_d = PEND_ONE;
		end else if ((b & MASK_TOP4) == LEAD3_PREFIX) begin
			partial_d = {b[3:0], 12'h000};
			pending_d = PEND_TWO;
		end else begin
			// Four-byte lead or stray continuation: stop the string.
			stopped_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PEND_NONE;
			partial_q <= '0;
			written_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
			written_q <= written_d;
			stopped_q <= stopped_d;
		end
	end

	// Load a new result on accept, otherwise drop the valid once it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (unit_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_unit_q  <= emit_unit;
			out_last_q  <= emit_last;
			out_total_q <= emit_total;
		end
	end

	assign unit_out.valid      = out_valid_q;
	assign unit_out.code_unit  = out_unit_q;
	assign unit_out.is_last    = out_last_q;
	assign unit_out.unit_total = out_total_q;

endmodule

@@ verif/utf8_to_utf16_decoder_core_tb.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 stream transcoder core.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_core_tb;
	import u8u16_pkg::*;

	localparam int ITEM_TARGET   = 1700;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int TIMEOUT_NS    = 1_000_000;

	// Hand-picked opening stream, decoded at the reset capacity of 255:
	// ASCII extremes, two- and three-byte forms (overlong included), a stray
	// continuation, a four-byte lead, a bad continuation, a NUL cutting a
	// sequence short and an all-ones byte.
	localparam byte_t OPENING_BYTES [25] = '{
		8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC,
		8'hEF, 8'hBF, 8'hBF, 8'h00,
		8'h80, 8'h41, 8'h00,
		8'hF0, 8'h00,
		8'hE2, 8'h41, 8'h00,
		8'hE2, 8'h82, 8'h00,
		8'hFF
	};

	typedef struct packed {
		unit_t  code_unit;
		logic   is_last;
		count_t unit_total;
	} unit_rec_t;

	// Tracks the per-string decode state and holds the code units that the
	// accepted bytes are due to produce, oldest first.
	class transcode_tracker;
		byte_t     capacity;
		pend_t     pending;
		unit_t     partial;
		count_t    written;
		bit        halted;
		unit_rec_t due_units[$];

		function new();
			capacity = CAPACITY_RESET;
			restart();
		endfunction

		function void restart();
			pending = PEND_NONE;
			partial = '0;
			written = '0;
			halted  = 1'b0;
		endfunction

		function void set_capacity(byte_t value);
			capacity = value;
		endfunction

		function int outstanding();
			return due_units.size();
		endfunction

		function void push_unit(unit_t value);
			due_units.push_back('{code_unit: value, is_last: 1'b0, unit_total: '0});
			written = written + count_t'(1);
		endfunction

		// Advance the decode state by one byte; return 0 if the string was already stopped and the byte is dropped.
		function bit note_byte(byte_t b);
			int unsigned usable;
			if (b == NUL_BYTE) begin
				due_units.push_back('{code_unit: TERM_UNIT, is_last: 1'b1,
					unit_total: written + count_t'(1)});
				restart();
				return 1'b1;
			end
			if (halted)
				return 1'b0;
			if (pending != PEND_NONE) begin
				if ((b & MASK_TOP2) != CONT_PREFIX) begin
					pending = PEND_NONE;
					partial = '0;
					halted  = 1'b1;
				end else if (pending == PEND_TWO) begin
					partial = partial | (unit_t'(b & CONT_PAYLOAD) << 6);
					pending = PEND_ONE;
				end else begin
					pending = PEND_NONE;
					push_unit(partial | unit_t'(b & CONT_PAYLOAD));
					partial = '0;
				end
				return 1'b1;
			end
			// Room is checked only when a new sequence would start.
			usable = capacity / 2;
			usable = (usable > 0) ? usable - 1 : 0;
			if (written >= usable)
				halted = 1'b1;
			else if ((b & MASK_TOP1) == 8'h00)
				push_unit(unit_t'(b));
			else if ((b & MASK_TOP3) == LEAD2_PREFIX) begin
				partial = unit_t'(b & LEAD2_PAYLOAD) << 6;
				pending = PEND_ONE;
			end else if ((b & MASK_TOP4) == LEAD3_PREFIX) begin
				partial = unit_t'(b & LEAD3_PAYLOAD) << 12;
				pending = PEND_TWO;
			end else
				halted = 1'b1;
			return 1'b1;
		endfunction

		// Compare one delivered unit with the oldest due unit, field by field.
		function bit check_unit(unit_rec_t got, output string why);
			unit_rec_t want;
			why = "";
			if (due_units.size() == 0) begin
				why = $sformatf(" unit %04h arrived with nothing due", got.code_unit);
				return 1'b0;
			end
			want = due_units.pop_front();
			if (got.code_unit !== want.code_unit)
				why = {why, $sformatf(" code_unit %04h/%04h", got.code_unit, want.code_unit)};
			if (got.is_last !== want.is_last)
				why = {why, $sformatf(" is_last %0b/%0b", got.is_last, want.is_last)};
			if (got.unit_total !== want.unit_total)
				why = {why, $sformatf(" unit_total %0d/%0d", got.unit_total, want.unit_total)};
			return why == "";
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	byte_t cfg_wr_data;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	transcode_tracker sb;

	int errors;
	int used_items;
	int strings_done;
	int units_checked;
	int phases;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;

	unit_rec_t seen_unit;
	string     seen_why;

	utf8_to_utf16_decoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.byte_in    (byte_ch),
		.unit_out   (unit_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case a request never completes.
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("[%0t] unit mismatch (got/want):%s", $time, what);
	endtask

	// Observe both channels at the clock edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				void'(sb.note_byte(byte_ch.in_byte));
				used_items++;
			end
			if (unit_ch.valid && unit_ch.ready) begin
				seen_unit = '{code_unit: unit_ch.code_unit, is_last: unit_ch.is_last,
					unit_total: unit_ch.unit_total};
				if (!sb.check_unit(seen_unit, seen_why))
					report(seen_why);
				units_checked++;
				if (unit_ch.is_last)
					strings_done++;
			end
		end
	end

	// Receiver: random stall bursts, or one long hold-off on request so the
	// output register fills and the core pushes back on its byte input.
	initial begin
		unit_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				unit_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				unit_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				unit_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one byte and hold it until the request completes.
	task automatic send_byte(input byte_t b);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
	endtask

	// Drop valid and wait until every due unit has been delivered.
	task automatic drain_units();
		byte_ch.valid <= 1'b0;
		// Let the monitor note the byte accepted at this edge first.
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the capacity register with the core idle; the string may stay open.
	task automatic write_capacity(input byte_t value);
		drain_units();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.set_capacity(value);
		cfg_wr_en <= 1'b0;
	endtask

	// One code point: mostly well-formed one-, two- and three-byte forms with
	// random payload; when noisy, also stray continuations, four-byte leads
	// and leads followed by a byte that is not a continuation.
	task automatic send_piece(input bit noisy);
		int pick;
		pick = $urandom_range(0, noisy ? 99 : 89);
		if (pick < 35)
			send_byte(byte_t'($urandom_range(1, 127)));
		else if (pick < 60) begin
			send_byte(byte_t'($urandom_range(8'hC0, 8'hDF)));
			send_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
		end else if (pick < 90) begin
			send_byte(byte_t'($urandom_range(8'hE0, 8'hEF)));
			send_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
			send_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
		end else if (pick < 93)
			send_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
		else if (pick < 96)
			send_byte(byte_t'($urandom_range(8'hF0, 8'hFF)));
		else begin
			send_byte(byte_t'($urandom_range(8'hC0, 8'hEF)));
			if ($urandom_range(0, 1))
				send_byte(byte_t'($urandom_range(1, 127)));
			else
				send_byte(byte_t'($urandom_range(8'hC0, 8'hFF)));
		end
	endtask

	// A NUL-terminated string; now and then the NUL cuts a sequence short.
	task automatic send_string(input int n_pieces, input bit noisy);
		for (int i = 0; i < n_pieces; i++)
			send_piece(noisy && $urandom_range(0, 6) == 0);
		if ($urandom_range(0, 19) == 0)
			send_byte(byte_t'($urandom_range(8'hC0, 8'hEF)));
		send_byte(NUL_BYTE);
	endtask

	initial begin
		byte_t cap;
		int    n_pieces;
		sb = new();
		errors        = 0;
		used_items    = 0;
		strings_done  = 0;
		units_checked = 0;
		phases        = 0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		hold_req      = 1'b0;
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset capacity, receiver stalling at random.
		rx_idle = 1'b1;
		foreach (OPENING_BYTES[i])
			send_byte(OPENING_BYTES[i]);
		send_byte(NUL_BYTE);

		// Random phases, each at its own capacity. The first few pin the
		// extremes: nothing fits, the full 126 units, below two, one unit.
		while (used_items < ITEM_TARGET) begin
			if (used_items > ITEM_TARGET * 4 / 5) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end else begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
			case (phases)
				0: cap = 8'd0;
				1: cap = 8'd255;
				2: cap = 8'd1;
				3: cap = 8'd4;
				default: begin
					case ($urandom_range(0, 9))
						0, 1: cap = byte_t'($urandom_range(0, 7));
						2: cap = byte_t'($urandom_range(250, 255));
						default: cap = byte_t'($urandom_range(8, 80));
					endcase
				end
			endcase
			write_capacity(cap);
			phases++;
			// Stall the receiver for a long stretch while a well-formed string keeps coming.
			if (phases == 2) begin
				hold_req = 1'b1;
				send_string(60, 1'b0);
			end
			repeat ($urandom_range(2, 5)) begin
				n_pieces = ($urandom_range(0, 11) == 0) ?
					$urandom_range(100, 140) : $urandom_range(0, 12);
				send_string(n_pieces, $urandom_range(0, 9) < 3);
			end
			// Leave a string open so the next capacity write lands mid-string.
			if ($urandom_range(0, 3) == 0)
				send_piece(1'b0);
		end

		drain_units();
		$display("Covered %0d input bytes, %0d strings and %0d units", used_items,
			strings_done, units_checked);
		$display("over %0d capacity settings, with a long output hold-off", phases);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
